>>> design/utv_pkg.sv
// shared types, constants and helper functions of the utf-8 title validator
// no dependencies; used by utv_decode and utf8_title_validator_unit
`default_nettype none
package utv_pkg;

	// width of the byte and code point totals
	localparam int CNT_W = 16;
	localparam int LIMIT_W = 16;
	localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

	// lead byte ranges
	localparam logic [7:0] LEAD1_HI = 8'h7f;
	localparam logic [7:0] LEAD2_LO = 8'hc2;
	localparam logic [7:0] LEAD2_HI = 8'hdf;
	localparam logic [7:0] LEAD3_LO = 8'he0;
	localparam logic [7:0] LEAD3_SURR = 8'hed;
	localparam logic [7:0] LEAD3_HI = 8'hef;
	localparam logic [7:0] LEAD4_LO = 8'hf0;
	localparam logic [7:0] LEAD4_HI = 8'hf4;
	localparam logic [1:0] CONT_TAG = 2'b10;

	// code point bounds
	localparam logic [20:0] MIN_THREE = 21'h000800;
	localparam logic [20:0] SURR_LO = 21'h00d800;
	localparam logic [20:0] SURR_HI = 21'h00dfff;
	localparam logic [20:0] MIN_FOUR = 21'h010000;
	localparam logic [20:0] MAX_CODE = 21'h10ffff;
	localparam logic [20:0] CTRL_LOW_END = 21'h000020;
	localparam logic [20:0] CTRL_HIGH_LO = 21'h00007f;
	localparam logic [20:0] CTRL_HIGH_HI = 21'h00009f;

	// sequence lengths
	localparam logic [2:0] SEQ_ONE = 3'd1;
	localparam logic [2:0] SEQ_TWO = 3'd2;
	localparam logic [2:0] SEQ_THREE = 3'd3;
	localparam logic [2:0] SEQ_FOUR = 3'd4;

	// configuration register indexes
	localparam logic REG_BYTE_LIMIT = 1'b0;
	localparam logic REG_CHAR_LIMIT = 1'b1;

	localparam logic [LIMIT_W-1:0] BYTE_LIMIT_RST = 16'd4096;
	localparam logic [LIMIT_W-1:0] CHAR_LIMIT_RST = 16'd1024;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_MALFORMED = 2'd1,
		STATUS_TOO_LARGE = 2'd2
	} status_t;

	// per-string decoder state
	typedef struct packed {
		logic [1:0]       bytes_pending;
		logic [7:0]       lead_value;
		logic [2:0]       seq_len;
		logic [20:0]      partial;
		logic             err;
		logic [CNT_W-1:0] byte_total;
		logic [CNT_W-1:0] char_total;
	} state_t;

	// one result word
	typedef struct packed {
		status_t     status;
		logic [15:0] char_count;
		logic [15:0] byte_count;
	} result_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (&v) ? v : CNT_W'(v + 1'b1);
	endfunction

	function automatic logic forbidden_code(input logic [20:0] cp);
		return (cp < CTRL_LOW_END) || ((cp >= CTRL_HIGH_LO) && (cp <= CTRL_HIGH_HI));
	endfunction

endpackage
`default_nettype wire

>>> design/utf8_title_validator_unit.sv
// top level of the utf-8 title validator: input register, state, result register
// depends on utv_pkg and utv_decode
//
// usage
//  - input channel (in_valid/in_ready): one string byte per word in data_byte,
//    last_byte high on the final byte of each string; strings hold one byte or more
//  - output channel (out_valid/out_ready): one word per string with status
//    (ok, malformed, too large), char_count and byte_count, both saturating
//  - configuration: cfg_we with cfg_index selects byte_limit or char_limit; the user
//    must write them only while no string is in flight, which the block does not enforce
//  - throughput: one byte per cycle while no final byte is held back; the decoder state loop is a
//    single combinational step between the input register and the state register
//  - result path: the final byte passes through the input register and then the
//    result register before the word shows on the output
//  - stall: while a result word waits, bytes keep flowing in and are decoded;
//    only the final byte of the next string holds in the input register until
//    the waiting word is taken
//  - reset: arst_n clears the decoder state, the valid flags and restores the
//    limits to 4096 bytes and 1024 code points; no clearing pass is needed
`default_nettype none
module utf8_title_validator_unit (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [7:0]                       data_byte,
	input  wire logic                             last_byte,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [1:0]                            status,
	output logic [15:0]                           char_count,
	output logic [15:0]                           byte_count,
	input  wire logic                             cfg_we,
	input  wire logic                             cfg_index,
	input  wire logic [utv_pkg::LIMIT_W-1:0]      cfg_wdata
);

	// configuration registers
	logic [utv_pkg::LIMIT_W-1:0] byte_limit_q;
	logic [utv_pkg::LIMIT_W-1:0] char_limit_q;

	// input register
	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;

	// decoder state and result register
	utv_pkg::state_t  state_q;
	utv_pkg::state_t  state_nx;
	utv_pkg::result_t res_nx;
	utv_pkg::result_t res_q;
	logic             out_valid_q;

	logic s1_go;
	logic in_take;

	// a byte in the input register moves on unless it would produce a word
	// while the result register is still full and not being taken
	assign s1_go = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || s1_go;
	assign in_take = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_limit_q <= utv_pkg::BYTE_LIMIT_RST;
			char_limit_q <= utv_pkg::CHAR_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				utv_pkg::REG_BYTE_LIMIT: byte_limit_q <= cfg_wdata;
				utv_pkg::REG_CHAR_LIMIT: char_limit_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// input register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (in_take) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	utv_decode u_decode (
		.st         (state_q),
		.data_byte  (data_s1),
		.last_byte  (last_s1),
		.byte_limit (byte_limit_q),
		.char_limit (char_limit_q),
		.nx         (state_nx),
		.res        (res_nx)
	);

	// decoder state, cleared after every final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (s1_go) begin
			state_q <= state_nx;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && last_s1) begin
			res_q <= res_nx;
		end
	end

	assign out_valid = out_valid_q;
	assign status = res_q.status;
	assign char_count = res_q.char_count;
	assign byte_count = res_q.byte_count;

`ifndef NO_ASSERTIONS
	// an error always drops any pending continuation bytes
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q.err |-> (state_q.bytes_pending == 2'd0))
		else $error("pending bytes left after error");

	// every code point takes at least one byte
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q.char_total <= state_q.byte_total)
		else $error("code point total above byte total");

	// a final byte leaves the decoder state cleared and a word ready
	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && last_s1) |=> ((state_q == '0) && out_valid_q))
		else $error("final byte did not clear state or raise result");

	// an ok word never exceeds either limit
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (res_q.status == utv_pkg::STATUS_OK)) |->
		((res_q.byte_count <= byte_limit_q) && (res_q.char_count <= char_limit_q)))
		else $error("ok status with a limit exceeded");

	// a final byte never overwrites a word that is still waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready && valid_s1 && last_s1) |-> !s1_go)
		else $error("result word overwritten");
`endif

endmodule
`default_nettype wire

>>> design/utv_decode.sv
// single-pass utf-8 decode step: next decoder state and the result word
// depends on utv_pkg
`default_nettype none
module utv_decode (
	input  wire utv_pkg::state_t                 st,
	input  wire logic [7:0]                      data_byte,
	input  wire logic                            last_byte,
	input  wire logic [utv_pkg::LIMIT_W-1:0]     byte_limit,
	input  wire logic [utv_pkg::LIMIT_W-1:0]     char_limit,
	output utv_pkg::state_t                      nx,
	output utv_pkg::result_t                     res
);

	logic [20:0] cp;
	logic [1:0]  pend_m1;
	logic        bad;
	logic        fin_err;
	logic        bytes_over;
	logic        chars_over;

	always_comb begin
		nx = st;
		nx.byte_total = utv_pkg::sat_inc(st.byte_total);
		cp = {st.partial[14:0], data_byte[5:0]};
		pend_m1 = st.bytes_pending - 2'd1;
		bad = ((st.seq_len == utv_pkg::SEQ_THREE) && (st.lead_value == utv_pkg::LEAD3_LO)
				&& (cp < utv_pkg::MIN_THREE))
			|| ((st.seq_len == utv_pkg::SEQ_THREE) && (st.lead_value == utv_pkg::LEAD3_SURR)
				&& (cp >= utv_pkg::SURR_LO))
			|| ((st.seq_len == utv_pkg::SEQ_FOUR) && (st.lead_value == utv_pkg::LEAD4_LO)
				&& (cp < utv_pkg::MIN_FOUR))
			|| (cp > utv_pkg::MAX_CODE)
			|| ((cp >= utv_pkg::SURR_LO) && (cp <= utv_pkg::SURR_HI))
			|| utv_pkg::forbidden_code(cp);

		if (!st.err) begin
			if (st.bytes_pending == 2'd0) begin
				nx.lead_value = data_byte;
				case (data_byte) inside
					[8'h00:utv_pkg::LEAD1_HI]: begin
						nx.seq_len = utv_pkg::SEQ_ONE;
						if (utv_pkg::forbidden_code({13'd0, data_byte})) begin
							nx.err = 1'b1;
						end else begin
							nx.char_total = utv_pkg::sat_inc(st.char_total);
						end
					end
					[utv_pkg::LEAD2_LO:utv_pkg::LEAD2_HI]: begin
						nx.seq_len = utv_pkg::SEQ_TWO;
						nx.partial = {16'd0, data_byte[4:0]};
						nx.bytes_pending = 2'd1;
					end
					[utv_pkg::LEAD3_LO:utv_pkg::LEAD3_HI]: begin
						nx.seq_len = utv_pkg::SEQ_THREE;
						nx.partial = {17'd0, data_byte[3:0]};
						nx.bytes_pending = 2'd2;
					end
					[utv_pkg::LEAD4_LO:utv_pkg::LEAD4_HI]: begin
						nx.seq_len = utv_pkg::SEQ_FOUR;
						nx.partial = {18'd0, data_byte[2:0]};
						nx.bytes_pending = 2'd3;
					end
					default: begin
						nx.err = 1'b1;
					end
				endcase
			end else if (data_byte[7:6] != utv_pkg::CONT_TAG) begin
				nx.err = 1'b1;
				nx.bytes_pending = 2'd0;
			end else begin
				nx.partial = cp;
				nx.bytes_pending = pend_m1;
				if (pend_m1 == 2'd0) begin
					if (bad) begin
						nx.err = 1'b1;
					end else begin
						nx.char_total = utv_pkg::sat_inc(st.char_total);
					end
				end
			end
		end

		// truncated sequence at end of string counts as malformed, unless the byte limit is exceeded
		fin_err = nx.err || (nx.bytes_pending != 2'd0);
		bytes_over = utv_pkg::CMP_W'(nx.byte_total) > utv_pkg::CMP_W'(byte_limit);
		chars_over = utv_pkg::CMP_W'(nx.char_total) > utv_pkg::CMP_W'(char_limit);

		if (bytes_over) begin
			res.status = utv_pkg::STATUS_TOO_LARGE;
		end else if (fin_err) begin
			res.status = utv_pkg::STATUS_MALFORMED;
		end else if (chars_over) begin
			res.status = utv_pkg::STATUS_TOO_LARGE;
		end else begin
			res.status = utv_pkg::STATUS_OK;
		end
		res.char_count = 16'(nx.char_total);
		res.byte_count = 16'(nx.byte_total);

		if (last_byte) begin
			nx = '0;
		end
	end

endmodule
`default_nettype wire
